// ----- rtl/core/tlr_pkg.sv -----
`timescale 1ns / 1ps

package tlr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int ERR_BITS      = COORD_BITS + 1;
    localparam int MAX_THICKNESS = 16;
    localparam int THICK_BITS    = 5;
    localparam int COLOR_BITS    = 24;
    localparam int IDX_BITS      = (MAX_THICKNESS > 1) ? $clog2(MAX_THICKNESS) : 1;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = COLOR_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_COLOR    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_THICKNESS = 1'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam logic [COLOR_BITS-1:0] PIXEL_COLOR_RST    = 24'd15;
    localparam logic [THICK_BITS-1:0] LINE_THICKNESS_RST = 5'd1;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic        [COLOR_BITS-1:0] color_out;
        logic                         last_of_step;
        logic                         line_done;
    } t_out_beat;

endpackage

// ----- rtl/core/thick_line_rasterizer.sv -----
`timescale 1ns / 1ps

// Load beats produce no pixels. A step beat accepted while a line is active
// produces line_thickness pixels (clamped to 1 to 16), one per cycle unless
// the output stalls, passing through the sequencer and the output register;
// the pixel sequencer sets the rate, so a new step is taken in the cycle its
// predecessor's last pixel moves out. Synchronous active-low reset clears
// the line state and sets color 15, thickness 1.
module thick_line_rasterizer
    import tlr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_beat                 i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_beat                o_out
);

    logic [COLOR_BITS-1:0] r_pixel_color;
    logic [THICK_BITS-1:0] r_line_thickness;

    // line state
    logic                  r_busy, n_busy;
    logic                  r_x_major, n_x_major;
    logic [COORD_BITS-1:0] r_major_pos, n_major_pos;
    logic [COORD_BITS-1:0] r_major_end, n_major_end;
    logic [COORD_BITS-1:0] r_minor_pos, n_minor_pos;
    logic [1:0]            r_minor_step, n_minor_step;
    logic [ERR_BITS-1:0]   r_error_acc, n_error_acc;
    logic [COORD_BITS-1:0] r_major_delta, n_major_delta;
    logic [COORD_BITS-1:0] r_minor_delta, n_minor_delta;

    // pixel sequencer
    logic                  r_gen_valid;
    logic [IDX_BITS-1:0]   r_gen_idx;
    logic [IDX_BITS-1:0]   r_gen_last;
    logic                  r_gen_xmaj;
    logic                  r_gen_done;
    logic [COORD_BITS-1:0] r_gen_major;
    logic [COORD_BITS-1:0] r_gen_minor;

    // output register
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic                  out_free;
    logic                  gen_fire;
    logic                  gen_finish;
    logic                  in_accept;
    logic                  step_start;

    // load setup
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic        [COORD_BITS:0]   abs_x, abs_y;
    logic        [COORD_BITS-1:0] dx, dy;
    logic                         ld_xmaj;
    logic signed [COORD_BITS-1:0] pa, pb, qa, qb;
    logic signed [COORD_BITS-1:0] pa_s, pb_s, qa_s, qb_s;

    // step update
    logic [ERR_BITS-1:0]   err_sum;
    logic                  step_done;
    logic [THICK_BITS-1:0] thick_clamped;

    // pixel compute
    logic [IDX_BITS:0]     idx_p1;
    logic [COORD_BITS-1:0] mag;
    logic [COORD_BITS-1:0] minor_px;
    t_out_beat             pix;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign gen_fire   = r_gen_valid && out_free;
    assign gen_finish = gen_fire && (r_gen_idx == r_gen_last);
    assign o_in_stall = r_gen_valid && !gen_finish;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign step_start = in_accept && (i_in.mode == MODE_STEP) && r_busy;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        diff_x = {i_in.start_x[COORD_BITS-1], i_in.start_x}
               - {i_in.end_x[COORD_BITS-1], i_in.end_x};
        diff_y = {i_in.start_y[COORD_BITS-1], i_in.start_y}
               - {i_in.end_y[COORD_BITS-1], i_in.end_y};
        abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
        abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
        dx     = abs_x[COORD_BITS-1:0];
        dy     = abs_y[COORD_BITS-1:0];
        ld_xmaj = dy < dx;
        if (ld_xmaj) begin
            pa = i_in.start_x; pb = i_in.end_x;
            qa = i_in.start_y; qb = i_in.end_y;
        end else begin
            pa = i_in.start_y; pb = i_in.end_y;
            qa = i_in.start_x; qb = i_in.end_x;
        end
        // swap so the major coordinate rises
        if (pa > pb) begin
            pa_s = pb; pb_s = pa; qa_s = qb; qb_s = qa;
        end else begin
            pa_s = pa; pb_s = pb; qa_s = qa; qb_s = qb;
        end
    end

    always_comb begin
        err_sum   = r_error_acc + {1'b0, r_minor_delta};
        step_done = (r_major_pos == r_major_end);

        if (r_line_thickness == '0) begin
            thick_clamped = THICK_BITS'(1);
        end else if (32'(r_line_thickness) > MAX_THICKNESS) begin
            thick_clamped = THICK_BITS'(MAX_THICKNESS);
        end else begin
            thick_clamped = r_line_thickness;
        end

        n_busy        = r_busy;
        n_x_major     = r_x_major;
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_pos   = r_minor_pos;
        n_minor_step  = r_minor_step;
        n_error_acc   = r_error_acc;
        n_major_delta = r_major_delta;
        n_minor_delta = r_minor_delta;

        if (in_accept && i_in.mode == MODE_LOAD) begin
            n_busy        = 1'b1;
            n_x_major     = ld_xmaj;
            n_major_pos   = pa_s;
            n_major_end   = pb_s;
            n_minor_pos   = qa_s;
            n_error_acc   = '0;
            n_major_delta = ld_xmaj ? dx : dy;
            n_minor_delta = ld_xmaj ? dy : dx;
            if (qb_s > qa_s) begin
                n_minor_step = 2'b01;
            end else if (qb_s < qa_s) begin
                n_minor_step = 2'b11;
            end else begin
                n_minor_step = 2'b00;
            end
        end else if (step_start) begin
            if (err_sum >= {1'b0, r_major_delta}) begin
                n_minor_pos = r_minor_pos
                            + {{(COORD_BITS-2){r_minor_step[1]}}, r_minor_step};
                n_error_acc = err_sum - {1'b0, r_major_delta};
            end else begin
                n_error_acc = err_sum;
            end
            if (step_done) begin
                n_busy = 1'b0;
            end else begin
                n_major_pos = r_major_pos + COORD_BITS'(1);
            end
        end
    end

    // offsets 0,-1,+1,-2,+2,...
    always_comb begin
        idx_p1   = {1'b0, r_gen_idx} + (IDX_BITS+1)'(1);
        mag      = COORD_BITS'(idx_p1[IDX_BITS:1]);
        minor_px = r_gen_idx[0] ? (r_gen_minor - mag) : (r_gen_minor + mag);
        pix.pixel_x      = r_gen_xmaj ? r_gen_major : minor_px;
        pix.pixel_y      = r_gen_xmaj ? minor_px : r_gen_major;
        pix.color_out    = r_pixel_color;
        pix.last_of_step = (r_gen_idx == r_gen_last);
        pix.line_done    = r_gen_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_color    <= PIXEL_COLOR_RST;
            r_line_thickness <= LINE_THICKNESS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIXEL_COLOR:    r_pixel_color    <= i_cfg_data[COLOR_BITS-1:0];
                CFG_LINE_THICKNESS: r_line_thickness <= i_cfg_data[THICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_x_major     <= 1'b0;
            r_major_pos   <= '0;
            r_major_end   <= '0;
            r_minor_pos   <= '0;
            r_minor_step  <= '0;
            r_error_acc   <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
        end else begin
            r_busy        <= n_busy;
            r_x_major     <= n_x_major;
            r_major_pos   <= n_major_pos;
            r_major_end   <= n_major_end;
            r_minor_pos   <= n_minor_pos;
            r_minor_step  <= n_minor_step;
            r_error_acc   <= n_error_acc;
            r_major_delta <= n_major_delta;
            r_minor_delta <= n_minor_delta;
        end
    end

    // sequencer valid and pixel index; the next block snapshots the major position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_valid <= 1'b0;
            r_gen_idx   <= '0;
        end else if (step_start) begin
            r_gen_valid <= 1'b1;
            r_gen_idx   <= '0;
        end else if (gen_finish) begin
            r_gen_valid <= 1'b0;
        end else if (gen_fire) begin
            r_gen_idx   <= r_gen_idx + IDX_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_start) begin
            r_gen_last  <= IDX_BITS'(thick_clamped - THICK_BITS'(1));
            r_gen_xmaj  <= r_x_major;
            r_gen_done  <= step_done;
            r_gen_major <= r_major_pos;
            r_gen_minor <= r_minor_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_gen_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_fire) begin
            r_out <= pix;
        end
    end

endmodule
